FILE: hw/rtl/mmc3_outer_bank_mapper_unit_macros.svh
// ----------------------------------------------------------------------------
// mmc3 outer bank mapper assertion macros
// shared assertion forms; every user has clk and rst_n in scope
// ----------------------------------------------------------------------------
`ifndef MMC3_OUTER_BANK_MAPPER_UNIT_MACROS_SVH
`define MMC3_OUTER_BANK_MAPPER_UNIT_MACROS_SVH

// condition holds, consequence holds in the same cycle
`define MOB_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// condition holds, consequence holds in the next cycle
`define MOB_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hw/rtl/mob_pkg.sv
// ----------------------------------------------------------------------------
// mob_pkg
// shared types and constants of the mmc3 outer bank mapper
// ----------------------------------------------------------------------------
package mob_pkg;

  localparam int PRG_W     = 9;
  localparam int CHR_W     = 11;
  localparam int NUM_PRG   = 4;
  localparam int NUM_CHR   = 8;
  localparam int NUM_SLOTS = NUM_PRG + NUM_CHR;
  localparam int DVD_W     = 9;
  localparam int REM_STEPS = DVD_W;
  localparam int SLOT_W    = 4;
  localparam int STEP_W    = 4;

  // item kinds
  localparam logic [1:0] FUNC_CPU   = 2'd0;
  localparam logic [1:0] FUNC_OUTER = 2'd1;
  localparam logic [1:0] FUNC_TICK  = 2'd2;

  // configuration register indexes
  localparam logic [1:0] CFG_PRG_COUNT   = 2'd0;
  localparam logic [1:0] CFG_CHR_COUNT   = 2'd1;
  localparam logic [1:0] CFG_FOUR_SCREEN = 2'd2;

  // cpu write decode on address bits 15,14,13,0
  localparam logic [3:0] DEC_BANK_SELECT = 4'b1000;
  localparam logic [3:0] DEC_BANK_DATA   = 4'b1001;
  localparam logic [3:0] DEC_MIRROR      = 4'b1010;
  localparam logic [3:0] DEC_IRQ_LATCH   = 4'b1100;
  localparam logic [3:0] DEC_IRQ_RELOAD  = 4'b1101;
  localparam logic [3:0] DEC_IRQ_DISABLE = 4'b1110;
  localparam logic [3:0] DEC_IRQ_ENABLE  = 4'b1111;

  // bank data targets chosen by bank select bits 2:0
  localparam logic [2:0] BSEL_CHR_PAIR0  = 3'd0;
  localparam logic [2:0] BSEL_CHR_PAIR1  = 3'd1;
  localparam logic [2:0] BSEL_CHR_SINGLE0 = 3'd2;
  localparam logic [2:0] BSEL_CHR_SINGLE1 = 3'd3;
  localparam logic [2:0] BSEL_CHR_SINGLE2 = 3'd4;
  localparam logic [2:0] BSEL_CHR_SINGLE3 = 3'd5;
  localparam logic [2:0] BSEL_PRG0       = 3'd6;
  localparam logic [2:0] BSEL_PRG1       = 3'd7;

  localparam logic [15:0] OUTER_PRG_ADDR = 16'h6000;
  localparam logic [15:0] OUTER_CHR_ADDR = 16'h6001;

  localparam logic [PRG_W-1:0] PRG_COUNT_RST = 9'd32;
  localparam logic [CHR_W-1:0] CHR_COUNT_RST = 11'd256;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_START,
    ST_WAIT,
    ST_DONE
  } mob_state_t;

  typedef struct packed {
    logic             start;
    logic [DVD_W-1:0] dividend;
    logic [CHR_W-1:0] divisor;
  } rem_req_t;

  typedef struct packed {
    logic             done;
    logic [CHR_W-1:0] remainder;
  } rem_rsp_t;

endpackage

FILE: hw/rtl/mob_rem_unit.sv
// ----------------------------------------------------------------------------
// mob_rem_unit
// bit-serial restoring remainder unit, one dividend bit per cycle
// ----------------------------------------------------------------------------
`include "mmc3_outer_bank_mapper_unit_macros.svh"

module mob_rem_unit
  import mob_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  rem_req_t req,
  output rem_rsp_t rsp
);

  logic [STEP_W-1:0] cnt_r, cnt_nxt;
  logic              done_r, done_nxt;
  logic [DVD_W-1:0]  dvd_r, dvd_nxt;
  logic [CHR_W-1:0]  dvs_r, dvs_nxt;
  logic [CHR_W-1:0]  rem_r, rem_nxt;
  logic [CHR_W:0]    shifted;
  logic [CHR_W:0]    diff;

  always_comb begin
    shifted  = {rem_r, dvd_r[DVD_W-1]};
    diff     = shifted - {1'b0, dvs_r};
    cnt_nxt  = cnt_r;
    done_nxt = 1'b0;
    dvd_nxt  = dvd_r;
    dvs_nxt  = dvs_r;
    rem_nxt  = rem_r;
    if (req.start) begin
      cnt_nxt = STEP_W'(REM_STEPS);
      dvd_nxt = req.dividend;
      dvs_nxt = req.divisor;
      rem_nxt = '0;
    end else if (cnt_r != '0) begin
      // keep the partial remainder below the divisor
      if (shifted >= {1'b0, dvs_r}) begin
        rem_nxt = diff[CHR_W-1:0];
      end else begin
        rem_nxt = shifted[CHR_W-1:0];
      end
      dvd_nxt  = {dvd_r[DVD_W-2:0], 1'b0};
      cnt_nxt  = cnt_r - 1'b1;
      done_nxt = (cnt_r == STEP_W'(1));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      cnt_r  <= cnt_nxt;
      done_r <= done_nxt;
    end
    dvd_r <= dvd_nxt;
    dvs_r <= dvs_nxt;
    rem_r <= rem_nxt;
  end

  // a zero bank count reads as bank 0
  assign rsp.done      = done_r;
  assign rsp.remainder = (dvs_r == '0) ? '0 : rem_r;

  `MOB_ASSERT_NEXT(a_done_single, done_r, !done_r, "remainder done held for two cycles")
  `MOB_ASSERT_NOW(a_rem_below_divisor, done_r && (dvs_r != '0), rem_r < dvs_r,
                  "remainder not below divisor")
  `MOB_ASSERT_NEXT(a_start_runs, req.start, (cnt_r == STEP_W'(REM_STEPS)) && !done_r,
                   "start did not load the step count")

endmodule

FILE: hw/rtl/mmc3_outer_bank_mapper_unit.sv
// ----------------------------------------------------------------------------
// mmc3_outer_bank_mapper_unit
// mmc3 style bank mapper with outer prg/chr bank registers
// ----------------------------------------------------------------------------
// Usage:
//   input channel in_valid/in_stall carries one item: a cpu write to
//   8000-ffff, a write to the 6000/6001 outer registers, or a scanline tick.
//   the register update happens at the edge where the item is accepted.
//   every item gives one result item on out_valid/out_stall: four prg bank
//   numbers, eight chr bank numbers, the mirroring and an irq pulse.
//   each of the twelve bank numbers is reduced modulo its bank count by one
//   shared bit-serial remainder unit, slot by slot. in_stall is high from
//   acceptance until the result is loaded, so no new item is taken while
//   one is in work; the sequencer over the remainder unit sets in_stall.
//   the finished result sits in an output register, so once it is loaded
//   a new item is taken while the receiver still stalls; a stalled result
//   holds its value. if the previous result was not taken, the block
//   waits. the user must write bank counts and the four-screen flag on
//   the cfg port only while idle; the block does not enforce it.
//   synchronous reset restores all mapper registers and the default counts.
// ----------------------------------------------------------------------------
`include "mmc3_outer_bank_mapper_unit_macros.svh"

module mmc3_outer_bank_mapper_unit
  import mob_pkg::*;
(
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cfg_we,
  input  logic [1:0]                   cfg_index,
  input  logic [CHR_W-1:0]             cfg_data,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [1:0]                   in_func,
  input  logic [15:0]                  in_addr,
  input  logic [7:0]                   in_data,
  input  logic                         in_visible_line,
  input  logic                         in_rendering_on,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [NUM_PRG*PRG_W-1:0]     out_prg_banks,
  output logic [NUM_PRG*CHR_W-1:0]     out_chr_banks_low,
  output logic [NUM_PRG*CHR_W-1:0]     out_chr_banks_high,
  output logic                         out_mirror_horizontal,
  output logic                         out_irq_request
);

  localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(NUM_SLOTS - 1);

  mob_state_t state_r, state_nxt;

  logic [PRG_W-1:0] prg_count_r, prg_count_nxt;
  logic [CHR_W-1:0] chr_count_r, chr_count_nxt;
  logic             four_screen_r, four_screen_nxt;

  logic [7:0] bank_select_r, bank_select_nxt;
  logic [6:0] chr_pair_r [2];   // bits 7:1, bit 0 comes from the slot within the pair
  logic [6:0] chr_pair_nxt [2];
  logic [7:0] chr_single_r [4];
  logic [7:0] chr_single_nxt [4];
  logic [7:0] prg_switch_r [2];
  logic [7:0] prg_switch_nxt [2];
  logic [7:0] outer_prg_r, outer_prg_nxt;
  logic       outer_chr_r, outer_chr_nxt;
  logic       irq_enabled_r, irq_enabled_nxt;
  logic [7:0] irq_count_r, irq_count_nxt;
  logic [7:0] irq_reload_r, irq_reload_nxt;
  logic       mirroring_r, mirroring_nxt;
  logic       irq_flag_r, irq_flag_nxt;

  logic [SLOT_W-1:0] slot_r, slot_nxt;
  logic [PRG_W-1:0]  prg_res_r [NUM_PRG];
  logic [CHR_W-1:0]  chr_res_r [NUM_CHR];

  logic out_valid_r;
  logic [NUM_PRG*PRG_W-1:0] out_prg_r;
  logic [NUM_PRG*CHR_W-1:0] out_chr_low_r;
  logic [NUM_PRG*CHR_W-1:0] out_chr_high_r;
  logic                     out_mirror_r;
  logic                     out_irq_r;

  logic in_acc;
  logic out_free;
  logic slot_store;
  logic out_load;
  logic rem_start;

  rem_req_t req;
  rem_rsp_t rsp;

  // slot operand selection
  logic              is_prg;
  logic [1:0]        prg_k;
  logic [SLOT_W-1:0] chr_off;
  logic [2:0]        chr_k;
  logic [PRG_W-1:0]  fix0;
  logic [PRG_W-1:0]  fix1;
  logic [PRG_W-1:0]  prg_val;
  logic              sel_single;
  logic [7:0]        chr_val;

  assign in_acc   = in_valid && !in_stall;
  assign out_free = !out_valid_r || !out_stall;

  // ---------------- configuration and mapper registers ----------------
  always_comb begin
    prg_count_nxt   = prg_count_r;
    chr_count_nxt   = chr_count_r;
    four_screen_nxt = four_screen_r;
    if (cfg_we) begin
      case (cfg_index)
        CFG_PRG_COUNT:   prg_count_nxt   = cfg_data[PRG_W-1:0];
        CFG_CHR_COUNT:   chr_count_nxt   = cfg_data;
        CFG_FOUR_SCREEN: four_screen_nxt = cfg_data[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    bank_select_nxt = bank_select_r;
    chr_pair_nxt    = chr_pair_r;
    chr_single_nxt  = chr_single_r;
    prg_switch_nxt  = prg_switch_r;
    outer_prg_nxt   = outer_prg_r;
    outer_chr_nxt   = outer_chr_r;
    irq_enabled_nxt = irq_enabled_r;
    irq_count_nxt   = irq_count_r;
    irq_reload_nxt  = irq_reload_r;
    mirroring_nxt   = mirroring_r;
    irq_flag_nxt    = irq_flag_r;
    if (in_acc) begin
      irq_flag_nxt = 1'b0;
      case (in_func)
        FUNC_CPU: begin
          case ({in_addr[15:13], in_addr[0]})
            DEC_BANK_SELECT: bank_select_nxt = in_data;
            DEC_BANK_DATA: begin
              case (bank_select_r[2:0])
                BSEL_CHR_PAIR0:   chr_pair_nxt[0]   = in_data[7:1];
                BSEL_CHR_PAIR1:   chr_pair_nxt[1]   = in_data[7:1];
                BSEL_CHR_SINGLE0: chr_single_nxt[0] = in_data;
                BSEL_CHR_SINGLE1: chr_single_nxt[1] = in_data;
                BSEL_CHR_SINGLE2: chr_single_nxt[2] = in_data;
                BSEL_CHR_SINGLE3: chr_single_nxt[3] = in_data;
                BSEL_PRG0:        prg_switch_nxt[0] = in_data;
                BSEL_PRG1:        prg_switch_nxt[1] = in_data;
                default: ;
              endcase
            end
            DEC_MIRROR: begin
              if (!four_screen_r) begin
                mirroring_nxt = in_data[0];
              end
            end
            DEC_IRQ_LATCH: begin
              irq_count_nxt   = in_data;
              irq_enabled_nxt = 1'b1;
            end
            DEC_IRQ_RELOAD:  irq_reload_nxt  = in_data;
            DEC_IRQ_DISABLE: irq_enabled_nxt = 1'b0;
            DEC_IRQ_ENABLE:  irq_enabled_nxt = 1'b1;
            default: ;
          endcase
        end
        FUNC_OUTER: begin
          if (in_addr == OUTER_PRG_ADDR) begin
            outer_prg_nxt = in_data;
          end else if (in_addr == OUTER_CHR_ADDR) begin
            outer_chr_nxt = in_data[0];
          end
        end
        FUNC_TICK: begin
          if (in_visible_line && in_rendering_on && irq_enabled_r) begin
            if (irq_count_r == '0) begin
              irq_count_nxt = irq_reload_r;
              irq_flag_nxt  = 1'b1;
            end else begin
              irq_count_nxt = irq_count_r - 1'b1;
            end
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prg_count_r     <= PRG_COUNT_RST;
      chr_count_r     <= CHR_COUNT_RST;
      four_screen_r   <= 1'b0;
      bank_select_r   <= '0;
      chr_pair_r[0]   <= 7'd0;
      chr_pair_r[1]   <= 7'd1;
      chr_single_r[0] <= 8'd4;
      chr_single_r[1] <= 8'd5;
      chr_single_r[2] <= 8'd6;
      chr_single_r[3] <= 8'd7;
      prg_switch_r[0] <= 8'd0;
      prg_switch_r[1] <= 8'd1;
      outer_prg_r     <= '0;
      outer_chr_r     <= 1'b0;
      irq_enabled_r   <= 1'b0;
      irq_count_r     <= '0;
      irq_reload_r    <= '0;
      mirroring_r     <= 1'b0;
      irq_flag_r      <= 1'b0;
    end else begin
      prg_count_r   <= prg_count_nxt;
      chr_count_r   <= chr_count_nxt;
      four_screen_r <= four_screen_nxt;
      bank_select_r <= bank_select_nxt;
      chr_pair_r    <= chr_pair_nxt;
      chr_single_r  <= chr_single_nxt;
      prg_switch_r  <= prg_switch_nxt;
      outer_prg_r   <= outer_prg_nxt;
      outer_chr_r   <= outer_chr_nxt;
      irq_enabled_r <= irq_enabled_nxt;
      irq_count_r   <= irq_count_nxt;
      irq_reload_r  <= irq_reload_nxt;
      mirroring_r   <= mirroring_nxt;
      irq_flag_r    <= irq_flag_nxt;
    end
  end

  // ---------------- slot operands ----------------
  // slots 0-3 are prg, 4-11 are chr
  always_comb begin
    is_prg     = (slot_r < SLOT_W'(NUM_PRG));
    prg_k      = slot_r[1:0];
    chr_off    = slot_r - SLOT_W'(NUM_PRG);
    chr_k      = chr_off[2:0];
    fix0       = prg_count_r - PRG_W'(2);
    fix1       = prg_count_r - PRG_W'(1);
    prg_val    = '0;
    if (outer_prg_r[7]) begin
      prg_val = {4'b0, outer_prg_r[3:0], 1'b0} + {7'b0, prg_k};
    end else begin
      case (prg_k)
        2'd0:    prg_val = bank_select_r[6] ? fix0 : {1'b0, prg_switch_r[0]};
        2'd1:    prg_val = {1'b0, prg_switch_r[1]};
        2'd2:    prg_val = bank_select_r[6] ? {1'b0, prg_switch_r[0]} : fix0;
        default: prg_val = fix1;
      endcase
    end
    // bank select bit 7 swaps the 2 KB and 1 KB halves
    sel_single = chr_k[2] ^ bank_select_r[7];
    if (sel_single) begin
      chr_val = chr_single_r[chr_k[1:0]];
    end else begin
      chr_val = {chr_pair_r[chr_k[1]], chr_k[0]};
    end
    req.start    = rem_start;
    req.dividend = is_prg ? prg_val : {outer_chr_r, chr_val};
    req.divisor  = is_prg ? {2'b0, prg_count_r} : chr_count_r;
  end

  // ---------------- sequencer ----------------
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE:  if (in_valid) state_nxt = ST_START;
      ST_START: state_nxt = ST_WAIT;
      ST_WAIT: begin
        if (rsp.done) begin
          state_nxt = (slot_r == LAST_SLOT) ? ST_DONE : ST_START;
        end
      end
      ST_DONE:  if (out_free) state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    in_stall   = (state_r != ST_IDLE);
    rem_start  = (state_r == ST_START);
    slot_store = (state_r == ST_WAIT) && rsp.done;
    out_load   = (state_r == ST_DONE) && out_free;
    slot_nxt   = slot_r;
    if (state_r == ST_IDLE) begin
      slot_nxt = '0;
    end else if (slot_store && (slot_r != LAST_SLOT)) begin
      slot_nxt = slot_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      slot_r  <= '0;
    end else begin
      state_r <= state_nxt;
      slot_r  <= slot_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (slot_store) begin
      if (is_prg) begin
        prg_res_r[prg_k] <= rsp.remainder[PRG_W-1:0];
      end else begin
        chr_res_r[chr_k] <= rsp.remainder;
      end
    end
  end

  mob_rem_unit u_rem (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (req),
    .rsp   (rsp)
  );

  // ---------------- output register ----------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
    if (out_load) begin
      out_prg_r      <= {prg_res_r[3], prg_res_r[2], prg_res_r[1], prg_res_r[0]};
      out_chr_low_r  <= {chr_res_r[3], chr_res_r[2], chr_res_r[1], chr_res_r[0]};
      out_chr_high_r <= {chr_res_r[7], chr_res_r[6], chr_res_r[5], chr_res_r[4]};
      out_mirror_r   <= mirroring_r;
      out_irq_r      <= irq_flag_r;
    end
  end

  assign out_valid             = out_valid_r;
  assign out_prg_banks         = out_prg_r;
  assign out_chr_banks_low     = out_chr_low_r;
  assign out_chr_banks_high    = out_chr_high_r;
  assign out_mirror_horizontal = out_mirror_r;
  assign out_irq_request       = out_irq_r;

  `MOB_ASSERT_NEXT(a_busy_after_accept, in_acc, in_stall && (state_r == ST_START),
                   "item accepted but sequencer not started")
  `MOB_ASSERT_NEXT(a_done_delivers, out_load, out_valid && (state_r == ST_IDLE),
                   "result not loaded into output register")
  `MOB_ASSERT_NOW(a_slot_range, state_r != ST_IDLE, slot_r <= LAST_SLOT,
                  "slot index beyond last slot")
  `MOB_ASSERT_NOW(a_no_start_busy, state_r == ST_WAIT, !req.start,
                  "remainder unit restarted while busy")

endmodule
